### rtl/mrcc_pkg.sv
// Package for the mixed-radix coordinate counter.
// Holds the sizes, register and command codes, sequencer states and the
// structs that run between the blocks. No dependencies.
package mrcc_pkg;

    localparam int MAX_DIMS    = 6;
    localparam int DIM_BITS    = 3;
    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 32;
    localparam int CNT_BITS    = 5;
    localparam int COORDS_BITS = MAX_DIMS * COORD_BITS;

    localparam logic [DIM_BITS-1:0] CFG_NUM_DIMS = 3'd0;
    localparam logic [DIM_BITS-1:0] CFG_RADIX_0  = 3'd1;
    localparam logic [DIM_BITS-1:0] CFG_RADIX_5  = 3'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_START,
        ST_LOAD_WAIT,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]                  last_dim;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0]  radix;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [INDEX_BITS-1:0] dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [INDEX_BITS-1:0] quotient;
        logic [COORD_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/mixed_radix_coordinate_counter.sv
// Top level: configuration registers, sequencer, shared divider.
// Step walks the carry through the dimensions it passes; load runs the divider
//   once per active dimension (start the divider, wait for its result, store).
// Requests: one at a time; the next is taken only after the result is
//   registered and the sequencer is back in idle; a stalled result holds it.
// Reset: coordinates 1, num_dims 1, every radix 1, no result pending.
module mixed_radix_coordinate_counter
    import mrcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [INDEX_BITS-1:0]  s_axis_tdata,   // linear_index
    input  logic                   s_axis_tuser,   // cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [COORDS_BITS-1:0] m_axis_tdata,   // coord_0 .. coord_5
    output logic                   m_axis_tuser,   // wrapped
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [DIM_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]  cfg_data
);

    logic [DIM_BITS-1:0]                 num_dims_reg;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] radix_reg;
    cfg_t                                cfg;
    div_req_t                            div_req;
    div_rsp_t                            div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= DIM_BITS'(1);
            for (int d = 0; d < MAX_DIMS; d++)
                radix_reg[d] <= COORD_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index) inside
                CFG_NUM_DIMS:
                    num_dims_reg <= cfg_data[DIM_BITS-1:0];
                [CFG_RADIX_0:CFG_RADIX_5]:
                    radix_reg[cfg_index - CFG_RADIX_0] <= cfg_data;
                default:
                    num_dims_reg <= num_dims_reg;
            endcase
        end
    end

    always_comb
    begin
        if (num_dims_reg == '0)
            cfg.last_dim = '0;
        else if (num_dims_reg > DIM_BITS'(MAX_DIMS))
            cfg.last_dim = DIM_BITS'(MAX_DIMS - 1);
        else
            cfg.last_dim = num_dims_reg - DIM_BITS'(1);
        for (int d = 0; d < MAX_DIMS; d++)
            cfg.radix[d] = (radix_reg[d] == '0) ? COORD_BITS'(1) : radix_reg[d];
    end

    mrcc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_index    (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_coords  (m_axis_tdata),
        .out_wrapped (m_axis_tuser),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    mrcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### rtl/mrcc_div.sv
// Restoring divider, one quotient bit per cycle.
// 32-bit dividend by 16-bit divisor. Depends on mrcc_pkg.
module mrcc_div
    import mrcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [INDEX_BITS-1:0] quo_reg, quo_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[INDEX_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            quo_next = {quo_reg[INDEX_BITS-2:0], ge};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == {CNT_BITS{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/mrcc_ctrl.sv
// Sequencer and coordinate store: load walks the dimensions through the
// shared divider, step walks them through one increment/compare unit.
// Depends on mrcc_pkg; drives mrcc_div through div_req/div_rsp.
module mrcc_ctrl
    import mrcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_cmd,
    input  logic [INDEX_BITS-1:0]  in_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORDS_BITS-1:0] out_coords,
    output logic                   out_wrapped,
    output div_req_t               div_req,
    input  div_rsp_t               div_rsp
);

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0]                 dim_reg, dim_next;
    logic [INDEX_BITS-1:0]               rest_reg, rest_next;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_reg, coord_next;
    logic                                wrap_reg, wrap_next;
    logic                                out_valid_reg, out_valid_next;
    logic [COORDS_BITS-1:0]              out_data_reg, out_data_next;
    logic                                out_wrap_reg, out_wrap_next;

    logic                  accept;
    logic                  out_free;
    logic                  last;
    logic [COORD_BITS:0]   inc;
    logic                  fits;
    logic [COORDS_BITS-1:0] shown;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last     = dim_reg == cfg.last_dim;
    assign inc      = {1'b0, coord_reg[dim_reg]} + (COORD_BITS+1)'(1);
    assign fits     = inc <= {1'b0, cfg.radix[dim_reg]};

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (DIM_BITS'(d) <= cfg.last_dim)
                shown[d*COORD_BITS +: COORD_BITS] = coord_reg[d];
            else
                shown[d*COORD_BITS +: COORD_BITS] = COORD_BITS'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (in_cmd == CMD_LOAD) ? ST_LOAD_START : ST_STEP;
            end
            ST_LOAD_START:
                state_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT:
            begin
                if (div_rsp.done)
                    state_next = last ? ST_DONE : ST_LOAD_START;
            end
            ST_STEP:
            begin
                if (fits || last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rest_reg;
        div_req.divisor  = cfg.radix[dim_reg];
        case (state_reg)
            ST_IDLE:       in_ready      = 1'b1;
            ST_LOAD_START: div_req.start = 1'b1;
            default:
            begin
                in_ready      = 1'b0;
                div_req.start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        dim_next       = dim_reg;
        rest_next      = rest_reg;
        coord_next     = coord_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_wrap_next  = out_wrap_reg;
        if (accept)
        begin
            dim_next  = '0;
            rest_next = in_index - INDEX_BITS'(1);
            wrap_next = 1'b0;
        end
        if (state_reg == ST_LOAD_WAIT && div_rsp.done)
        begin
            coord_next[dim_reg] = div_rsp.remainder + COORD_BITS'(1);
            rest_next           = div_rsp.quotient;
            dim_next            = dim_reg + DIM_BITS'(1);
        end
        if (state_reg == ST_STEP)
        begin
            if (fits)
                coord_next[dim_reg] = inc[COORD_BITS-1:0];
            else
            begin
                coord_next[dim_reg] = COORD_BITS'(1);
                dim_next            = dim_reg + DIM_BITS'(1);
                wrap_next           = last;
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = shown;
            out_wrap_next  = wrap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++)
                coord_reg[d] <= COORD_BITS'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            coord_reg     <= coord_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dim_reg      <= dim_next;
        rest_reg     <= rest_next;
        wrap_reg     <= wrap_next;
        out_data_reg <= out_data_next;
        out_wrap_reg <= out_wrap_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_coords  = out_data_reg;
    assign out_wrapped = out_wrap_reg;

endmodule

### rtl/mrcc_checker.sv
// Port-level checks for the mixed-radix coordinate counter, bound to the top.
// Depends on mrcc_pkg.
module mrcc_port_checks
    import mrcc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [COORDS_BITS-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // one request in flight
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // coordinates are 1-based
    a_coords_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[31:16] != 16'd0 &&
            m_axis_tdata[47:32] != 16'd0 && m_axis_tdata[63:48] != 16'd0 &&
            m_axis_tdata[79:64] != 16'd0 && m_axis_tdata[95:80] != 16'd0)
        else $error("zero coordinate in result");

endmodule

bind mixed_radix_coordinate_counter mrcc_port_checks u_mrcc_port_checks (.*);
